FILE: design/sbps_pkg.sv
package sbps_pkg;

  typedef struct packed {
    logic       kind;
    logic [7:0] data_byte;
  } item_t;

  typedef struct packed {
    logic       status;
    logic [7:0] read_data;
  } result_t;

  localparam logic KIND_WRITE = 1'b0;
  localparam logic KIND_READ  = 1'b1;

  localparam logic STATUS_OK   = 1'b0;
  localparam logic STATUS_FAIL = 1'b1;

  localparam logic [7:0] OP_READ_CODE    = 8'h21;
  localparam logic [7:0] OP_WRITE_CODE   = 8'h31;
  localparam logic [7:0] REG_POWER_CODE  = 8'hB3;
  localparam logic [7:0] REG_SAMPLE_CODE = 8'hC3;
  localparam logic [7:0] ADDR_RESET      = 8'hE3;

  localparam int          PADDR_WIDTH      = 3;
  localparam logic        REG_DEVICE_ADDR  = 1'b0;

  // Contents of the sample buffer after reset; entries past the tenth read zero.
  function automatic logic [7:0] sample_init(input logic [7:0] idx);
    logic [7:0] v;
    case (idx)
      8'd0:    v = 8'd238;
      8'd1:    v = 8'd54;
      8'd2:    v = 8'd191;
      8'd3:    v = 8'd174;
      8'd4:    v = 8'd103;
      8'd5:    v = 8'd228;
      8'd6:    v = 8'd184;
      8'd7:    v = 8'd57;
      8'd8:    v = 8'd206;
      8'd9:    v = 8'd13;
      default: v = 8'd0;
    endcase
    return v;
  endfunction

endpackage

FILE: design/sbps_ram.sv
module sbps_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 10
) (
  input  logic                                   clk,
  input  logic                                   we,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                       wdata,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                       rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

FILE: design/sbps_regs.sv
module sbps_regs (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            psel,
  input  logic                            penable,
  input  logic                            pwrite,
  input  logic [sbps_pkg::PADDR_WIDTH-1:0] paddr,
  input  logic [31:0]                     pwdata,
  output logic [31:0]                     prdata,
  output logic                            pready,
  output logic [7:0]                      device_address
);

  logic wr_en;

  assign pready = 1'b1;
  assign wr_en  = psel && penable && pwrite && (paddr[2] == sbps_pkg::REG_DEVICE_ADDR);

  always_ff @(posedge clk) begin
    if (rst) begin
      device_address <= sbps_pkg::ADDR_RESET;
    end else if (wr_en) begin
      device_address <= pwdata[7:0];
    end
  end

  always_comb begin
    prdata = 32'd0;
    if (paddr[2] == sbps_pkg::REG_DEVICE_ADDR) begin
      prdata = {24'd0, device_address};
    end
  end

endmodule

FILE: design/sbps_engine.sv
module sbps_engine #(
  parameter int SAMPLE_DEPTH = 10,
  parameter int MODE_COUNT   = 2
) (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    fire,
  input  sbps_pkg::item_t         item,
  input  logic [7:0]              device_address,
  output sbps_pkg::result_t       result
);

  localparam int CW = SAMPLE_DEPTH > 1 ? $clog2(SAMPLE_DEPTH) : 1;

  typedef enum logic [1:0] {
    PH_IDLE,
    PH_OPEN,
    PH_REGSEL,
    PH_OPERATION
  } phase_t;

  typedef enum logic [1:0] {
    LOP_NONE,
    LOP_READ,
    LOP_WRITE
  } lop_t;

  typedef enum logic [1:0] {
    LREG_NONE,
    LREG_POWER,
    LREG_SAMPLE
  } lreg_t;

  phase_t            phase, phase_next;
  lop_t              lop, lop_next;
  lreg_t             lreg, lreg_next;
  logic [7:0]        power_mode, power_mode_next;
  logic [CW-1:0]     cursor, cursor_next, cursor_inc;
  logic [SAMPLE_DEPTH-1:0] written;
  logic              written_q;
  logic              byp;
  logic [7:0]        byp_data;
  logic [7:0]        ram_rdata;
  logic [7:0]        sample_rd;
  logic              we;
  logic              advance;
  logic [7:0]        d;

  assign d = item.data_byte;
  assign cursor_inc = (cursor == CW'(SAMPLE_DEPTH - 1)) ? '0 : cursor + 1'b1;

  // The buffer entry at the cursor is read ahead of use.
  always_comb begin
    if (byp) begin
      sample_rd = byp_data;
    end else if (written_q) begin
      sample_rd = ram_rdata;
    end else begin
      sample_rd = sbps_pkg::sample_init(8'(cursor));
    end
  end

  always_comb begin
    phase_next      = phase;
    lop_next        = lop;
    lreg_next       = lreg;
    power_mode_next = power_mode;
    we              = 1'b0;
    advance         = 1'b0;
    result.status    = sbps_pkg::STATUS_OK;
    result.read_data = 8'd0;
    if (item.kind == sbps_pkg::KIND_WRITE) begin
      case (phase)
        PH_IDLE: begin
          if (d == device_address) begin
            phase_next = PH_OPEN;
          end else begin
            result.status = sbps_pkg::STATUS_FAIL;
          end
        end
        PH_OPEN: begin
          if (d == device_address) begin
            phase_next = PH_IDLE;
          end else if (d == sbps_pkg::OP_READ_CODE) begin
            lop_next   = LOP_READ;
            phase_next = PH_REGSEL;
          end else if (d == sbps_pkg::OP_WRITE_CODE) begin
            lop_next   = LOP_WRITE;
            phase_next = PH_REGSEL;
          end else begin
            result.status = sbps_pkg::STATUS_FAIL;
          end
        end
        PH_REGSEL: begin
          if (d == device_address) begin
            phase_next = PH_IDLE;
          end else if (d == sbps_pkg::REG_POWER_CODE) begin
            lreg_next  = LREG_POWER;
            phase_next = PH_OPERATION;
          end else if (d == sbps_pkg::REG_SAMPLE_CODE) begin
            lreg_next  = LREG_SAMPLE;
            phase_next = PH_OPERATION;
          end else begin
            result.status = sbps_pkg::STATUS_FAIL;
          end
        end
        default: begin
          phase_next = PH_IDLE;
          if (lop != LOP_WRITE) begin
            result.status = sbps_pkg::STATUS_FAIL;
          end else if (lreg == LREG_POWER) begin
            if ({1'b0, d} >= 9'(MODE_COUNT)) begin
              result.status = sbps_pkg::STATUS_FAIL;
            end else begin
              power_mode_next = d;
            end
          end else if (lreg == LREG_SAMPLE) begin
            we      = 1'b1;
            advance = 1'b1;
          end
        end
      endcase
    end else begin
      phase_next = PH_IDLE;
      if (phase != PH_OPERATION || lop != LOP_READ) begin
        result.status = sbps_pkg::STATUS_FAIL;
      end else if (lreg == LREG_POWER) begin
        result.read_data = power_mode;
      end else if (lreg == LREG_SAMPLE) begin
        result.read_data = sample_rd;
        advance          = 1'b1;
      end
    end
    if (!fire) begin
      phase_next      = phase;
      lop_next        = lop;
      lreg_next       = lreg;
      power_mode_next = power_mode;
      we              = 1'b0;
      advance         = 1'b0;
    end
    cursor_next = advance ? cursor_inc : cursor;
  end

  sbps_ram #(
    .WIDTH(8),
    .DEPTH(SAMPLE_DEPTH)
  ) u_ram (
    .clk   (clk),
    .we    (we),
    .waddr (cursor),
    .wdata (d),
    .raddr (cursor_next),
    .rdata (ram_rdata)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      phase      <= PH_IDLE;
      lop        <= LOP_NONE;
      lreg       <= LREG_NONE;
      power_mode <= 8'd0;
      cursor     <= '0;
      written    <= '0;
      written_q  <= 1'b0;
      byp        <= 1'b0;
    end else begin
      phase      <= phase_next;
      lop        <= lop_next;
      lreg       <= lreg_next;
      power_mode <= power_mode_next;
      cursor     <= cursor_next;
      if (we) begin
        written[cursor] <= 1'b1;
      end
      written_q  <= written[cursor_next];
      byp        <= we && (cursor == cursor_next);
    end
    byp_data <= d;
  end

endmodule

FILE: design/sensor_byte_protocol_slave.sv
// Byte-wise slave of a mock accelerometer.
// Each item on the item channel is one bus access: kind 0 writes data_byte to
// the device, kind 1 reads a byte from it. The device address byte opens a
// transaction, an operation byte and a register byte follow, and the fourth
// access stores or returns the power mode or one sample buffer byte.
// Every item produces exactly one result item carrying status and read_data.
// An accepted item is held in an input register, decoded when the result
// register can take it and written there, so a result item passes the input
// register and the result register. One item per cycle is sustained while
// result_ready stays high; the sample buffer read is issued ahead from the
// next cursor value, so the buffer port adds no stall.
// When the receiver holds result_ready low, the result register and the input
// register fill and item_ready falls; nothing is lost or repeated.
// The device address register sits on the APB port at byte addresses 0 to 3.
// After the synchronous reset the phase is idle, the power mode is zero,
// the cursor is zero, the buffer holds its initial samples and the device
// address is 0xE3; items are accepted in the first cycle after reset.
module sensor_byte_protocol_slave #(
  parameter int SAMPLE_DEPTH = 10,
  parameter int MODE_COUNT   = 2
) (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             item_valid,
  output logic                             item_ready,
  input  sbps_pkg::item_t                  item,
  output logic                             result_valid,
  input  logic                             result_ready,
  output sbps_pkg::result_t                result,
  input  logic                             psel,
  input  logic                             penable,
  input  logic                             pwrite,
  input  logic [sbps_pkg::PADDR_WIDTH-1:0] paddr,
  input  logic [31:0]                      pwdata,
  output logic [31:0]                      prdata,
  output logic                             pready
);

  logic              held_valid;
  sbps_pkg::item_t   held;
  logic              fire;
  sbps_pkg::result_t eng_result;
  logic [7:0]        device_address;

  assign fire       = held_valid && (!result_valid || result_ready);
  assign item_ready = !held_valid || fire;

  sbps_regs u_regs (
    .clk            (clk),
    .rst            (rst),
    .psel           (psel),
    .penable        (penable),
    .pwrite         (pwrite),
    .paddr          (paddr),
    .pwdata         (pwdata),
    .prdata         (prdata),
    .pready         (pready),
    .device_address (device_address)
  );

  sbps_engine #(
    .SAMPLE_DEPTH (SAMPLE_DEPTH),
    .MODE_COUNT   (MODE_COUNT)
  ) u_engine (
    .clk            (clk),
    .rst            (rst),
    .fire           (fire),
    .item           (held),
    .device_address (device_address),
    .result         (eng_result)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      held_valid   <= 1'b0;
      result_valid <= 1'b0;
    end else begin
      if (item_valid && item_ready) begin
        held_valid <= 1'b1;
      end else if (fire) begin
        held_valid <= 1'b0;
      end
      if (fire) begin
        result_valid <= 1'b1;
      end else if (result_ready) begin
        result_valid <= 1'b0;
      end
    end
    if (item_valid && item_ready) begin
      held <= item;
    end
    if (fire) begin
      result <= eng_result;
    end
  end

endmodule
